// ----- sv/bsr_pkg.sv -----
`default_nettype none

package bsr_pkg;

    localparam int DEPTH       = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int COUNT_W     = 5;
    localparam int DEFAULT_CAP = 4;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_POP     = 2'd1;
    localparam logic [1:0] KIND_PEEK    = 2'd2;
    localparam logic [1:0] KIND_REVERSE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
        logic                     is_full;
        logic                     is_empty;
    } t_out_item;

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0) begin
            res = CNT_W'(DEFAULT_CAP);
        end else if (32'(cap) > 32'(DEPTH)) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [ADDR_W-1:0] base,
        input logic              dir,
        input logic [ADDR_W-1:0] idx
    );
        logic [ADDR_W-1:0] res;
        if (dir) begin
            res = base - idx;
        end else begin
            res = base + idx;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bounded_stack_with_reverse_core.sv -----
// The status and RAM read of an accepted transaction are registered in a pending stage, then in the output register.
// Throughput: one transaction per cycle for every operation, reverse included, while the output is not stalled;
// the entry RAM is read or written at most once per transaction.
// Reverse flips the RAM addressing direction and rebases it instead of moving words.
// Reset (synchronous, active low) empties the stack and sets capacity to 16.
`default_nettype none

module bounded_stack_with_reverse_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire bsr_pkg::t_in_item                    i_in,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output bsr_pkg::t_out_item                        o_out,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [bsr_pkg::CAP_W-1:0]            i_cfg_data
);

    logic [bsr_pkg::CAP_W-1:0]  r_cap;
    logic [bsr_pkg::CNT_W-1:0]  r_count, n_count;
    logic [bsr_pkg::ADDR_W-1:0] r_base, n_base;
    logic                       r_dir, n_dir;

    logic                       r_pend;
    logic                       r_p_use;
    logic [1:0]                 r_p_status;
    logic [bsr_pkg::CNT_W-1:0]  r_p_count;
    logic                       r_p_full;
    logic                       r_p_empty;

    logic                       r_out_valid;
    bsr_pkg::t_out_item         r_out;

    logic                       acc;
    logic                       mv;
    logic [bsr_pkg::CNT_W-1:0]  cap;
    logic [bsr_pkg::ADDR_W-1:0] top_addr;
    logic [bsr_pkg::ADDR_W-1:0] push_addr;
    logic                       wr_en;
    logic                       use_rd;
    logic [1:0]                 status;
    logic [bsr_pkg::DATA_W-1:0] rd_data;

    assign mv          = r_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_pend || mv;
    assign acc         = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        cap       = bsr_pkg::eff_cap(r_cap);
        top_addr  = bsr_pkg::phys_addr(r_base, r_dir,
                        bsr_pkg::ADDR_W'(r_count - bsr_pkg::CNT_W'(1)));
        push_addr = bsr_pkg::phys_addr(r_base, r_dir, r_count[bsr_pkg::ADDR_W-1:0]);
        n_count   = r_count;
        n_base    = r_base;
        n_dir     = r_dir;
        wr_en     = 1'b0;
        use_rd    = 1'b0;
        status    = bsr_pkg::ST_OK;
        unique case (i_in.kind)
            bsr_pkg::KIND_PUSH: begin
                if (r_count >= cap) begin
                    status = bsr_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = acc;
                    n_count = r_count + bsr_pkg::CNT_W'(1);
                end
            end
            bsr_pkg::KIND_POP, bsr_pkg::KIND_PEEK: begin
                if (r_count == '0) begin
                    status = bsr_pkg::ST_EMPTY;
                end else begin
                    use_rd = 1'b1;
                    if (i_in.kind == bsr_pkg::KIND_POP) begin
                        n_count = r_count - bsr_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                n_base = top_addr;
                n_dir  = !r_dir;
            end
        endcase
    end

    bsr_ram #(
        .WIDTH (bsr_pkg::DATA_W),
        .WORDS (bsr_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (push_addr),
        .i_wdata (i_in.data),
        .i_re    (acc && use_rd),
        .i_raddr (top_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= bsr_pkg::CAP_W'(16);
            r_count     <= '0;
            r_base      <= '0;
            r_dir       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (acc) begin
                r_count <= n_count;
                r_base  <= n_base;
                r_dir   <= n_dir;
            end
            if (acc) begin
                r_pend <= 1'b1;
            end else if (mv) begin
                r_pend <= 1'b0;
            end
            if (mv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_use    <= use_rd;
            r_p_status <= status;
            r_p_count  <= n_count;
            r_p_full   <= (n_count >= cap);
            r_p_empty  <= (n_count == '0);
        end
        if (mv) begin
            r_out.value    <= r_p_use ? rd_data : '0;
            r_out.status   <= r_p_status;
            r_out.count    <= bsr_pkg::COUNT_W'(r_p_count);
            r_out.is_full  <= r_p_full;
            r_out.is_empty <= r_p_empty;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bsr_ram.sv -----
`default_nettype none

module bsr_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 16,
    parameter int AW    = $clog2(WORDS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/bsr_checker.sv -----
`default_nettype none

module bsr_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_ready,
    input wire bsr_pkg::t_in_item         i_in,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire bsr_pkg::t_out_item        o_out,
    input wire logic                      i_cfg_valid,
    input wire logic                      o_cfg_ready,
    input wire logic [bsr_pkg::CAP_W-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("Result transaction dropped or changed while stalled.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.count == '0)))
        else $error("Empty flag disagrees with count.");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == bsr_pkg::ST_OVERFLOW |-> o_out.is_full
            && o_out.value == '0)
        else $error("Overflow reported on a stack that is not full.");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == bsr_pkg::ST_EMPTY |->
            o_out.value == '0 && o_out.count == '0 && o_out.is_empty)
        else $error("Empty status with held entries or nonzero value.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.count) <= 32'(bsr_pkg::DEPTH)
            && o_out.status <= bsr_pkg::ST_EMPTY)
        else $error("Count beyond depth or undefined status.");

endmodule

bind bounded_stack_with_reverse_core bsr_checker u_bsr_checker (.*);

`default_nettype wire

// ----- sim/tb_bounded_stack_with_reverse_core.sv -----
`default_nettype none

module tb_bounded_stack_with_reverse_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 60;
    localparam logic signed [bsr_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [bsr_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    class stack_scoreboard;
        logic signed [bsr_pkg::DATA_W-1:0] words [bsr_pkg::DEPTH];
        int unsigned fill;
        logic [bsr_pkg::CAP_W-1:0] cap_reg;
        bsr_pkg::t_out_item expected_q [$];
        int errors;

        function new();
            foreach (words[i]) begin
                words[i] = '0;
            end
            fill = 0;
            cap_reg = bsr_pkg::CAP_W'(16);
            errors = 0;
        endfunction

        function void set_capacity(logic [bsr_pkg::CAP_W-1:0] v);
            cap_reg = v;
        endfunction

        function int unsigned limit();
            int unsigned c;
            c = cap_reg;
            if (c == 0) begin
                c = bsr_pkg::DEFAULT_CAP;
            end
            if (c > bsr_pkg::DEPTH) begin
                c = bsr_pkg::DEPTH;
            end
            return c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(bsr_pkg::t_in_item item);
            bsr_pkg::t_out_item res;
            int unsigned cap;
            logic signed [bsr_pkg::DATA_W-1:0] tmp;
            cap = limit();
            res = '0;
            res.status = bsr_pkg::ST_OK;
            case (item.kind)
                bsr_pkg::KIND_PUSH: begin
                    if (fill >= cap || fill >= bsr_pkg::DEPTH) begin
                        res.status = bsr_pkg::ST_OVERFLOW;
                    end else begin
                        words[fill] = item.data;
                        fill++;
                    end
                end
                bsr_pkg::KIND_POP, bsr_pkg::KIND_PEEK: begin
                    if (fill == 0) begin
                        res.status = bsr_pkg::ST_EMPTY;
                    end else begin
                        res.value = words[fill-1];
                        if (item.kind == bsr_pkg::KIND_POP) begin
                            fill--;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < int'(fill / 2); i++) begin
                        tmp = words[i];
                        words[i] = words[fill-1-i];
                        words[fill-1-i] = tmp;
                    end
                end
            endcase
            res.count = bsr_pkg::COUNT_W'(fill);
            res.is_full = (fill >= cap);
            res.is_empty = (fill == 0);
            expected_q.push_back(res);
        endfunction

        function void cmp(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(bsr_pkg::t_out_item got);
            bsr_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            cmp("value", longint'(want.value), longint'(got.value));
            cmp("status", longint'(want.status), longint'(got.status));
            cmp("count", longint'(want.count), longint'(got.count));
            cmp("is_full", longint'(want.is_full), longint'(got.is_full));
            cmp("is_empty", longint'(want.is_empty), longint'(got.is_empty));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    bsr_pkg::t_in_item i_in = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [bsr_pkg::CAP_W-1:0] i_cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    bsr_pkg::t_out_item o_out;
    logic o_cfg_ready;

    stack_scoreboard sb;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    bounded_stack_with_reverse_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out);
        end
    end

    function automatic logic [1:0] pick_kind(int push_pct);
        int r;
        if ($urandom_range(99) < push_pct) begin
            return bsr_pkg::KIND_PUSH;
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return bsr_pkg::KIND_POP;
        end else if (r < 85) begin
            return bsr_pkg::KIND_PEEK;
        end
        return bsr_pkg::KIND_REVERSE;
    endfunction

    function automatic logic signed [bsr_pkg::DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] kind,
                             input logic signed [bsr_pkg::DATA_W-1:0] data,
                             input int idle_pct);
        bsr_pkg::t_in_item item;
        item.kind = kind;
        item.data = data;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(item);
    endtask

    task automatic write_capacity(input logic [bsr_pkg::CAP_W-1:0] cap);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_capacity(cap);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [bsr_pkg::CAP_W-1:0] cap, input int n,
                             input int push_pct, input int send_idle, input int recv_stall,
                             input bit hold);
        recv_stall_pct = recv_stall;
        write_capacity(cap);
        if (hold) begin
            hold_req++;
        end
        repeat (n) send_item(pick_kind(push_pct), rand_word(), send_idle);
    endtask

    initial begin
        #2_400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Empty stack, single-entry reverse, and the word extremes.
        send_item(bsr_pkg::KIND_POP, $urandom, 0);
        send_item(bsr_pkg::KIND_PEEK, $urandom, 0);
        send_item(bsr_pkg::KIND_REVERSE, $urandom, 0);
        send_item(bsr_pkg::KIND_PUSH, WORD_MAX, 0);
        send_item(bsr_pkg::KIND_REVERSE, $urandom, 0);
        send_item(bsr_pkg::KIND_PEEK, $urandom, 0);
        send_item(bsr_pkg::KIND_PUSH, WORD_MIN, 0);
        send_item(bsr_pkg::KIND_PUSH, -1, 0);
        send_item(bsr_pkg::KIND_PUSH, '0, 0);
        send_item(bsr_pkg::KIND_REVERSE, $urandom, 0);
        send_item(bsr_pkg::KIND_PEEK, $urandom, 0);
        repeat (5) send_item(bsr_pkg::KIND_POP, $urandom, 0);

        // A zero capacity selects four; then the capacity drops below the count.
        write_capacity('0);
        repeat (5) send_item(bsr_pkg::KIND_PUSH, $urandom, 0);
        write_capacity(bsr_pkg::CAP_W'(2));
        send_item(bsr_pkg::KIND_PUSH, $urandom, 0);
        repeat (3) send_item(bsr_pkg::KIND_POP, $urandom, 0);

        run_phase(bsr_pkg::CAP_W'(16), 80, 60, 0, 0, 1'b0);
        run_phase(bsr_pkg::CAP_W'(16), 70, 30, 78, 0, 1'b0);
        run_phase(bsr_pkg::CAP_W'(1), 60, 50, 0, 78, 1'b0);
        run_phase(bsr_pkg::CAP_W'(7), 70, 55, 38, 38, 1'b0);
        run_phase(bsr_pkg::CAP_W'(0), 60, 60, 0, 0, 1'b1);
        run_phase(bsr_pkg::CAP_W'(16), 80, 65, 0, 38, 1'b1);
        run_phase(bsr_pkg::CAP_W'(10), 60, 45, 78, 0, 1'b0);
        run_phase(bsr_pkg::CAP_W'(16), 70, 40, 0, 78, 1'b0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/bsr_pkg.sv
sv/bsr_ram.sv
sv/bounded_stack_with_reverse_core.sv
sv/bsr_checker.sv
sim/tb_bounded_stack_with_reverse_core.sv
